[rtl/wdgs_pkg.sv]
// package with widths, codes and item types of the window density gap segmenter
`timescale 1ns / 1ps
package wdgs_pkg;
   localparam int POS_W      = 26;
   localparam int CNT_W      = 24;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 26;
   localparam int DIV_STEPS  = POS_W / 2;
   localparam int STEP_W     = $clog2(DIV_STEPS);
   localparam int MAX_RES    = 3;
   localparam int RES_IDX_W  = 2;

   localparam logic [POS_W-1:0] WIDTH_RESET     = POS_W'(131072);
   localparam logic [CNT_W-1:0] MIN_COUNT_RESET = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_MAX         = {CNT_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_WIDTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_COUNT    = 1'd1;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIV,
      F_PUSH
   } front_state_type;

   typedef struct packed {
      logic [POS_W-1:0] win;
      logic             last_site;
   } item_type;

   typedef struct packed {
      logic [CNT_W-1:0] start_site;
      logic             keep;
      logic             final_res;
   } result_type;
endpackage

[rtl/wdgs_if.sv]
// channel interfaces for site input, segment output and register writes
`timescale 1ns / 1ps
interface wdgs_req_if;
   import wdgs_pkg::*;
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] pos_cm;
   logic             last_site;
   modport source (output valid, output pos_cm, output last_site, input ready);
   modport sink (input valid, input pos_cm, input last_site, output ready);
endinterface

interface wdgs_rsp_if;
   import wdgs_pkg::*;
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] start_site;
   logic             keep;
   logic             final_res;
   modport source (output valid, output start_site, output keep, output final_res,
                    input ready);
   modport sink (input valid, input start_site, input keep, input final_res,
                 output ready);
endinterface

interface wdgs_csr_if;
   import wdgs_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/wdgs_front.sv]
// front end: accepts sites and finds the window index with a radix-4 restoring divider
`timescale 1ns / 1ps
module wdgs_front (
   input  logic                    clock,
   input  logic                    reset,
   wdgs_req_if.sink                req,
   input  logic [wdgs_pkg::POS_W-1:0] window_width,
   output logic                    out_valid,
   input  logic                    out_ready,
   output wdgs_pkg::item_type      out_item
);
   import wdgs_pkg::*;

   front_state_type   st_ff, st_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [POS_W-1:0]  num_ff, num_in;
   logic [POS_W-1:0]  rem_ff, rem_in;
   logic [POS_W-1:0]  quo_ff, quo_in;
   logic [POS_W-1:0]  div_ff, div_in;
   logic              last_ff, last_in;
   logic [POS_W:0]    r1, r2;
   logic              b1, b2;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= F_IDLE;
      end else begin
         st_ff <= st_in;
      end
      cnt_ff  <= cnt_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      div_ff  <= div_in;
      last_ff <= last_in;
   end

   always_comb begin
      st_in   = st_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      last_in = last_ff;
      r1 = {rem_ff, num_ff[POS_W-1]};
      b1 = r1 >= {1'b0, div_ff};
      if (b1) begin
         r1 = r1 - {1'b0, div_ff};
      end
      r2 = {r1[POS_W-1:0], num_ff[POS_W-2]};
      b2 = r2 >= {1'b0, div_ff};
      if (b2) begin
         r2 = r2 - {1'b0, div_ff};
      end
      req.ready = (st_ff == F_IDLE);
      out_valid = (st_ff == F_PUSH);
      out_item.win       = quo_ff;
      out_item.last_site = last_ff;
      unique case (st_ff)
         F_IDLE: begin
            if (req.valid) begin
               div_in  = (window_width == '0) ? POS_W'(1) : window_width;
               num_in  = req.pos_cm;
               rem_in  = '0;
               quo_in  = '0;
               cnt_in  = '0;
               last_in = req.last_site;
               st_in   = F_DIV;
            end
         end
         F_DIV: begin
            rem_in = r2[POS_W-1:0];
            num_in = {num_ff[POS_W-3:0], 2'b00};
            quo_in = {quo_ff[POS_W-3:0], b1, b2};
            cnt_in = cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_W'(DIV_STEPS - 1)) begin
               st_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (out_ready) begin
               st_in = F_IDLE;
            end
         end
         default: begin
            st_in = F_IDLE;
         end
      endcase
   end
endmodule

[rtl/wdgs_queue.sv]
// two-entry queue between the divider front end and the counting back end
`timescale 1ns / 1ps
module wdgs_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  wdgs_pkg::item_type in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output wdgs_pkg::item_type out_item
);
   import wdgs_pkg::*;

   item_type   mem_ff [2];
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic [1:0] num_ff, num_in;
   logic       push, pop;

   assign in_ready  = (num_ff != 2'd2);
   assign out_valid = (num_ff != 2'd0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      num_in = num_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         num_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         num_ff <= num_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= in_item;
      end
   end

   assign out_item = mem_ff[rp_ff];
endmodule

[rtl/wdgs_back.sv]
// back end: window counting, labelling, segment list and output register
`timescale 1ns / 1ps
module wdgs_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  wdgs_pkg::item_type      in_item,
   input  logic [wdgs_pkg::CNT_W-1:0] min_count,
   wdgs_rsp_if.source              rsp
);
   import wdgs_pkg::*;

   typedef struct packed {
      logic             emit;
      logic [CNT_W-1:0] start;
      logic             prev;
      logic             pend;
   } label_type;

   function automatic label_type label_step(input logic v, input logic lab,
                                            input logic [CNT_W-1:0] lb,
                                            input logic prev, input logic pend);
      label_type r;
      r.emit  = 1'b0;
      r.start = '0;
      r.prev  = prev;
      r.pend  = pend;
      if (v) begin
         if (pend) begin
            r.emit = 1'b1;
            r.prev = lab;
            r.pend = 1'b0;
         end else if (lab != prev) begin
            r.emit  = 1'b1;
            r.start = lab ? lb : ((lb != '0) ? lb - CNT_W'(1) : '0);
            r.prev  = lab;
         end
      end
      return r;
   endfunction

   logic [POS_W-1:0]     cw_ff, cw_in;
   logic [CNT_W-1:0]     wcnt_ff, wcnt_in;
   logic [CNT_W-1:0]     wfirst_ff, wfirst_in;
   logic [CNT_W-1:0]     site_ff, site_in;
   logic                 prev_ff, prev_in;
   logic                 started_ff, started_in;
   logic                 pend_ff, pend_in;
   result_type           res_ff [MAX_RES];
   result_type           lst [MAX_RES];
   logic [RES_IDX_W-1:0] num_ff, rd_ff, n;
   logic                 out_valid_ff, out_valid_in;
   result_type           out_ff;
   logic                 pending, pop, load, empty_lab;
   logic                 v1, l1, v2;
   logic [CNT_W-1:0]     lb1;
   logic [CNT_W-1:0]     cnt_n;
   logic [CNT_W-1:0]     first_n;
   logic [POS_W-1:0]     cw_n;
   label_type            s1, s2, s3;

   assign pending   = (rd_ff != num_ff);
   assign in_ready  = !pending;
   assign pop       = in_valid && !pending;
   assign load      = pending && (!out_valid_ff || rsp.ready);
   assign empty_lab = (min_count == '0);

   always_comb begin
      v1      = 1'b0;
      l1      = empty_lab;
      lb1     = site_ff;
      v2      = 1'b0;
      cw_n    = cw_ff;
      cnt_n   = wcnt_ff;
      first_n = wfirst_ff;
      if (!started_ff) begin
         v1      = (in_item.win != '0);
         cw_n    = in_item.win;
         cnt_n   = CNT_W'(1);
         first_n = site_ff;
      end else if (in_item.win > cw_ff) begin
         v1      = 1'b1;
         l1      = (wcnt_ff >= min_count);
         lb1     = wfirst_ff;
         v2      = {1'b0, in_item.win} > ({1'b0, cw_ff} + (POS_W + 1)'(1));
         cw_n    = in_item.win;
         cnt_n   = CNT_W'(1);
         first_n = site_ff;
      end else if (wcnt_ff != CNT_MAX) begin
         cnt_n = wcnt_ff + CNT_W'(1);
      end
      s1 = label_step(v1, l1, lb1, prev_ff, pend_ff);
      s2 = label_step(v2, empty_lab, site_ff, s1.prev, s1.pend);
      s3 = label_step(in_item.last_site, cnt_n >= min_count, first_n, s2.prev, s2.pend);

      for (int i = 0; i < MAX_RES; i++) begin
         lst[i] = '0;
      end
      n = '0;
      if (s1.emit) begin
         lst[n] = '{start_site: s1.start, keep: s1.prev, final_res: 1'b0};
         n = n + RES_IDX_W'(1);
      end
      if (s2.emit) begin
         lst[n] = '{start_site: s2.start, keep: s2.prev, final_res: 1'b0};
         n = n + RES_IDX_W'(1);
      end
      if (s3.emit) begin
         lst[n] = '{start_site: s3.start, keep: s3.prev, final_res: 1'b0};
         n = n + RES_IDX_W'(1);
      end
      if (n != '0) begin
         lst[n - RES_IDX_W'(1)].final_res = 1'b1;
      end

      cw_in      = cw_ff;
      wcnt_in    = wcnt_ff;
      wfirst_in  = wfirst_ff;
      site_in    = site_ff;
      prev_in    = prev_ff;
      started_in = started_ff;
      pend_in    = pend_ff;
      if (pop) begin
         if (in_item.last_site) begin
            cw_in      = '0;
            wcnt_in    = '0;
            wfirst_in  = '0;
            site_in    = '0;
            prev_in    = 1'b0;
            started_in = 1'b0;
            pend_in    = 1'b1;
         end else begin
            cw_in      = cw_n;
            wcnt_in    = cnt_n;
            wfirst_in  = first_n;
            site_in    = (site_ff == CNT_MAX) ? site_ff : site_ff + CNT_W'(1);
            prev_in    = s3.prev;
            started_in = 1'b1;
            pend_in    = s3.pend;
         end
      end

      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cw_ff        <= '0;
         wcnt_ff      <= '0;
         wfirst_ff    <= '0;
         site_ff      <= '0;
         prev_ff      <= 1'b0;
         started_ff   <= 1'b0;
         pend_ff      <= 1'b1;
         num_ff       <= '0;
         rd_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cw_ff        <= cw_in;
         wcnt_ff      <= wcnt_in;
         wfirst_ff    <= wfirst_in;
         site_ff      <= site_in;
         prev_ff      <= prev_in;
         started_ff   <= started_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
         if (pop) begin
            num_ff <= n;
            rd_ff  <= '0;
         end else if (load) begin
            rd_ff <= rd_ff + RES_IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         for (int i = 0; i < MAX_RES; i++) begin
            res_ff[i] <= lst[i];
         end
      end
      if (load) begin
         out_ff <= res_ff[rd_ff];
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.start_site = out_ff.start_site;
   assign rsp.keep       = out_ff.keep;
   assign rsp.final_res  = out_ff.final_res;

   a_first_at_zero: assert property (@(posedge clock) disable iff (reset)
      pop && pend_ff && (n != '0) |=> res_ff[0].start_site == '0)
      else $error("first segment of a stream does not start at site zero");

   a_final_is_last: assert property (@(posedge clock) disable iff (reset)
      load && res_ff[rd_ff].final_res |-> (rd_ff + RES_IDX_W'(1) == num_ff))
      else $error("final flag on a segment that is not the last of its site");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      pop && in_item.last_site |=> !started_ff && pend_ff && (site_ff == '0))
      else $error("stream state not cleared after the final site");
endmodule

[rtl/window_density_gap_segmenter_top.sv]
// top level of the window density gap segmenter
`timescale 1ns / 1ps
// Each site is transferred on the input side, goes through the front-end restoring divider
// that retires two quotient bits per cycle and is handed as a window index to a two-entry
// queue, after which the front end takes the next site. The back end pulls one queued site
// at a time, updates its window counters, then sends its zero to three segments from a registered
// output, one per cycle unless stalled by rsp.ready, while the divider already works on the next site.
// Register writes on the csr port are taken every cycle and are meant for an idle block.
module window_density_gap_segmenter_top (
   input  logic     clock,
   input  logic     reset,
   wdgs_req_if.sink req,
   wdgs_rsp_if.source rsp,
   wdgs_csr_if.sink csr
);
   import wdgs_pkg::*;

   logic [POS_W-1:0] width_ff, width_in;
   logic [CNT_W-1:0] minc_ff, minc_in;
   logic             f_valid, f_ready;
   item_type         f_item;
   logic             b_valid, b_ready;
   item_type         b_item;

   assign csr.ready = 1'b1;

   always_comb begin
      width_in = width_ff;
      minc_in  = minc_ff;
      if (csr.valid) begin
         unique case (csr.index)
            CSR_WINDOW_WIDTH: width_in = csr.data[POS_W-1:0];
            CSR_MIN_COUNT:    minc_in  = csr.data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
         minc_ff  <= MIN_COUNT_RESET;
      end else begin
         width_ff <= width_in;
         minc_ff  <= minc_in;
      end
   end

   wdgs_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req          (req),
      .window_width (width_ff),
      .out_valid    (f_valid),
      .out_ready    (f_ready),
      .out_item     (f_item)
   );

   wdgs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_item   (f_item),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_item  (b_item)
   );

   wdgs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b_valid),
      .in_ready  (b_ready),
      .in_item   (b_item),
      .min_count (minc_ff),
      .rsp       (rsp)
   );
endmodule
